[hw/rtl/ffsa_pkg.sv]
package ffsa_pkg;

  localparam int MaxSegments = 16;
  localparam int HeapBytes   = 65536;
  localparam int HeaderBytes = 16;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int CntW        = $clog2(MaxSegments + 1);

  localparam logic       FUNC_ALLOC  = 1'b0;
  localparam logic       FUNC_FREE   = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_NOMEM    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [15:0] block_addr;
  } ffsa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } ffsa_out_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        free;
  } ffsa_seg_t;

endpackage

[hw/rtl/first_fit_segment_allocator.sv]
// A zero-size request goes from accepting the input word straight to presenting the result word;
// any other request passes through the scan first, and then through the shift or merge states where needed.
// Allocate scans the table one entry per cycle, then may shift it up one entry
// per cycle; free scans, then merges, and each merge pulls the tail down one entry per cycle.
// Throughput: one word at a time; in_ready is low from acceptance until the result is taken.
// Reset (synchronous, rst_n low) empties the table and clears the heap top.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffsa_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ffsa_out_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  ffsa_seg_t tbl_r [MaxSegments];

  logic [2:0]      state_r;
  ffsa_in_t        req_r;
  logic [CntW-1:0] cnt_r;
  logic [16:0]     top_r;
  logic [CntW-1:0] i_r;
  logic [CntW-1:0] k_r;
  logic [CntW-1:0] j_r;
  ffsa_out_t       res_r;
  ffsa_seg_t       ins_r;

  // One shared comparator/adder path works on the entry at i_r.
  ffsa_seg_t   cur;
  logic [16:0] rest;
  logic [15:0] cur_data;
  logic [17:0] app_end;
  logic [IdxW-1:0] ii, kk, jj, jn, km;

  assign ii       = i_r[IdxW-1:0];
  assign kk       = k_r[IdxW-1:0];
  assign km       = kk - 1'b1;
  assign jj       = j_r[IdxW-1:0];
  assign jn       = jj + 1'b1;
  assign cur      = tbl_r[ii];
  assign rest     = {1'b0, cur.size} - {1'b0, req_r.req_size};
  assign cur_data = cur.start + 16'(HeaderBytes);
  assign app_end  = {1'b0, top_r} + 18'(HeaderBytes) + {2'b0, req_r.req_size};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      top_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            i_r   <= '0;
            if (in_data.func == FUNC_ALLOC && in_data.req_size == 16'd0) begin
              res_r   <= '{status: ST_ZERO, addr: 16'd0};
              state_r <= S_DONE;
            end else begin
              res_r   <= '{status: ST_OK, addr: 16'd0};
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (i_r == cnt_r) begin
            if (req_r.func == FUNC_FREE) begin
              res_r.status <= ST_NOTFOUND;
              state_r      <= S_DONE;
            end else if (cnt_r >= CntW'(MaxSegments) || app_end > 18'(HeapBytes)) begin
              res_r.status <= ST_NOMEM;
              state_r      <= S_DONE;
            end else begin
              tbl_r[ii]  <= '{start: top_r[15:0], size: req_r.req_size, free: 1'b0};
              cnt_r      <= cnt_r + 1'b1;
              res_r.addr <= top_r[15:0] + 16'(HeaderBytes);
              top_r      <= 17'(app_end);
              state_r    <= S_DONE;
            end
          end else if (req_r.func == FUNC_FREE) begin
            if (cur_data == req_r.block_addr) begin
              tbl_r[ii].free <= 1'b1;
              j_r            <= '0;
              state_r        <= S_MERGE;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else if (cur.free && cur.size > req_r.req_size) begin
            res_r.addr <= cur_data;
            if (rest >= 17'(HeaderBytes + 1) && cnt_r < CntW'(MaxSegments)) begin
              tbl_r[ii] <= '{start: cur.start, size: req_r.req_size, free: 1'b0};
              ins_r <= '{start: cur_data + req_r.req_size,
                         size: 16'(rest - 17'(HeaderBytes)), free: 1'b1};
              k_r     <= cnt_r;
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_SHIFT;
            end else begin
              tbl_r[ii].free <= 1'b0;
              state_r        <= S_DONE;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_SHIFT: begin
          // Open a hole above the split entry, one move per cycle.
          if (k_r == i_r + 1'b1) begin
            tbl_r[kk] <= ins_r;
            state_r   <= S_DONE;
          end else begin
            tbl_r[kk] <= tbl_r[km];
            k_r       <= k_r - 1'b1;
          end
        end
        S_MERGE: begin
          // While merging, k_r walks the tail down by one entry.
          if (j_r + 1'b1 >= cnt_r) begin
            state_r <= S_DONE;
          end else if (tbl_r[jj].free && tbl_r[jn].free) begin
            tbl_r[jj].size <= tbl_r[jj].size + 16'(HeaderBytes) + tbl_r[jn].size;
            k_r     <= j_r + 1'b1;
            state_r <= S_CLOSE;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_CLOSE: begin
          if (k_r + 1'b1 >= cnt_r) begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_MERGE;
          end else begin
            tbl_r[kk] <= tbl_r[kk + 1'b1];
            k_r       <= k_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_first_fit_segment_allocator.sv]
`timescale 1ns / 100ps

module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ffsa_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ffsa_out_t out_data;

  first_fit_segment_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted allocator state.
  logic [15:0] heap_start [MaxSegments];
  logic [15:0] heap_size [MaxSegments];
  logic        heap_free [MaxSegments];
  int          heap_count;
  int          heap_top;

  ffsa_out_t   pending_words [$];
  logic [15:0] live_addrs [$];
  int          errors;
  bit          hold_off;
  int          pause_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void merge_free_runs();
    int j;
    j = 0;
    while (j + 1 < heap_count) begin
      if (heap_free[j] && heap_free[j + 1]) begin
        heap_size[j] = 16'(heap_size[j] + HeaderBytes + heap_size[j + 1]);
        for (int k = j + 1; k + 1 < heap_count; k++) begin
          heap_start[k] = heap_start[k + 1];
          heap_size[k]  = heap_size[k + 1];
          heap_free[k]  = heap_free[k + 1];
        end
        heap_count--;
      end else begin
        j++;
      end
    end
  endfunction

  function automatic ffsa_out_t predict_word(ffsa_in_t w);
    ffsa_out_t r;
    int        rest;
    r.status = ST_OK;
    r.addr   = '0;
    if (w.func == FUNC_ALLOC) begin
      if (w.req_size == 0) begin
        r.status = ST_ZERO;
        return r;
      end
      for (int i = 0; i < heap_count; i++) begin
        if (heap_free[i] && heap_size[i] > w.req_size) begin
          rest = heap_size[i] - w.req_size;
          heap_free[i] = 1'b0;
          if (rest >= HeaderBytes + 1 && heap_count < MaxSegments) begin
            for (int k = heap_count; k > i + 1; k--) begin
              heap_start[k] = heap_start[k - 1];
              heap_size[k]  = heap_size[k - 1];
              heap_free[k]  = heap_free[k - 1];
            end
            heap_start[i + 1] = 16'(heap_start[i] + HeaderBytes + w.req_size);
            heap_size[i + 1]  = 16'(rest - HeaderBytes);
            heap_free[i + 1]  = 1'b1;
            heap_size[i]      = w.req_size;
            heap_count++;
          end
          r.addr = 16'(heap_start[i] + HeaderBytes);
          return r;
        end
      end
      if (heap_count >= MaxSegments || heap_top + HeaderBytes + w.req_size > HeapBytes) begin
        r.status = ST_NOMEM;
        return r;
      end
      heap_start[heap_count] = heap_top[15:0];
      heap_size[heap_count]  = w.req_size;
      heap_free[heap_count]  = 1'b0;
      heap_count++;
      r.addr   = 16'(heap_top + HeaderBytes);
      heap_top = heap_top + HeaderBytes + w.req_size;
    end else begin
      for (int i = 0; i < heap_count; i++) begin
        if (16'(heap_start[i] + HeaderBytes) == w.block_addr) begin
          heap_free[i] = 1'b1;
          merge_free_runs();
          return r;
        end
      end
      r.status = ST_NOTFOUND;
    end
    return r;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_word(ffsa_in_t w);
    ffsa_out_t r;
    int        gap;
    gap = short_gap();
    repeat (gap) @(posedge clk);
    r = predict_word(w);
    pending_words.push_back(r);
    if (w.func == FUNC_ALLOC && r.status == ST_OK) live_addrs.push_back(r.addr);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_alloc(logic [15:0] sz);
    ffsa_in_t w;
    w.func       = FUNC_ALLOC;
    w.req_size   = sz;
    w.block_addr = 16'($urandom());
    send_word(w);
  endtask

  task automatic send_free(logic [15:0] a);
    ffsa_in_t w;
    w.func       = FUNC_FREE;
    w.req_size   = 16'($urandom());
    w.block_addr = a;
    send_word(w);
  endtask

  // Frees a previously handed-out address, or a random one now and then.
  task automatic free_some();
    int idx;
    if (live_addrs.size() > 0 && $urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      send_free(live_addrs[idx]);
      live_addrs.delete(idx);
    end else begin
      send_free(16'($urandom()));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2 * MaxSegments + 8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_alloc(16'd0);
    send_free(16'd16);
    send_alloc(16'd1);
    send_alloc(16'd100);
    send_alloc(16'd40);
    send_free(16'd33);
    send_alloc(16'd10);
    send_alloc(16'd60);
    send_free(16'd33);
    send_free(16'd33);
    send_alloc(16'd20);
    send_free(16'hFFFF);
    send_alloc(16'hFFFF);
    send_alloc(16'hFFF0);
    send_alloc(16'h8000);
    send_alloc(16'h5555);
    send_alloc(16'hAAAA);
    wait_drained();
  endtask

  // Small requests fill the table so that splits run out of room.
  task automatic test_table_full();
    repeat (20) send_alloc(16'($urandom_range(1, 64)));
    repeat (8) free_some();
    repeat (10) send_alloc(16'($urandom_range(1, 200)));
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_alloc(16'($urandom_range(1, 300)));
        4:          send_alloc(16'($urandom()));
        5, 6, 7, 8: free_some();
        default:    send_alloc(16'($urandom_range(0, 2)));
      endcase
    end
    wait_drained();
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (6) send_alloc(16'($urandom_range(1, 50)));
    join_none
    pause_cycles = 0;
    while (pause_cycles < 300) begin
      @(posedge clk);
      pause_cycles++;
    end
    hold_off = 1'b0;
    wait fork;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    ffsa_out_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word status=%0d addr=%h", $time,
                 out_data.status, out_data.addr);
        errors++;
      end else begin
        exp_word = pending_words.pop_front();
        if (out_data.status !== exp_word.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_word.status, out_data.status);
          errors++;
        end
        if (out_data.addr !== exp_word.addr) begin
          $display("%0t: addr expected %h actual %h", $time,
                   exp_word.addr, out_data.addr);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    errors     = 0;
    hold_off   = 1'b0;
    heap_count = 0;
    heap_top   = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(1700);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ffsa_pkg.sv
hw/rtl/first_fit_segment_allocator.sv
tb/tb_first_fit_segment_allocator.sv
